// ===== rtl/core/lpc_pkg.sv =====
package lpc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_LAYER_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_BG_PRIORITIES   = 3'd1;
   localparam logic [2:0] CSR_BLEND_CONTROL   = 3'd2;
   localparam logic [2:0] CSR_ALPHA_FIRST     = 3'd3;
   localparam logic [2:0] CSR_ALPHA_SECOND    = 3'd4;
   localparam logic [2:0] CSR_BRIGHTNESS_STEP = 3'd5;
   localparam logic [2:0] CSR_WINDOWS_ENABLED = 3'd6;
   localparam logic [2:0] CSR_BACKDROP_COLOR  = 3'd7;

   // color effect codes, as in the effect field of blend_control
   localparam logic [1:0] FX_NONE     = 2'd0;
   localparam logic [1:0] FX_ALPHA    = 2'd1;
   localparam logic [1:0] FX_BRIGHTEN = 2'd2;
   localparam logic [1:0] FX_DARKEN   = 2'd3;

   // layer ids
   localparam logic [2:0] LAYER_SPRITE   = 3'd4;
   localparam logic [2:0] LAYER_BACKDROP = 3'd5;

   // priority code of the backdrop: lowest priority, layer five
   localparam logic [7:0] TOP_INIT   = 8'hF5;
   localparam int         OPAQUE_BIT = 15;
   localparam logic [4:0] COEF_MAX   = 5'd16;
   localparam logic [4:0] CHAN_MAX   = 5'd31;

   typedef struct packed {
      logic [3:0][15:0] bg_pixel;
      logic [14:0]      sprite_color;
      logic             sprite_opaque;
      logic [1:0]       sprite_priority;
      logic             sprite_semitransparent;
      logic [5:0]       window_mask;
   } req_type;

   typedef struct packed {
      logic [4:0]  layer_enable;
      logic [7:0]  bg_priorities;
      logic [13:0] blend_control;
      logic [4:0]  alpha_first;
      logic [4:0]  alpha_second;
      logic [4:0]  brightness_step;
      logic        windows_enabled;
      logic [15:0] backdrop_color;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  top_id;
      logic [2:0]  back_id;
      logic [15:0] top_pix;
      logic [14:0] back_color;
      logic [1:0]  fx_op;
   } sel_type;

endpackage

// ===== rtl/core/lpc_req_if.sv =====
interface lpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] bg0_pixel;
   logic [15:0] bg1_pixel;
   logic [15:0] bg2_pixel;
   logic [15:0] bg3_pixel;
   logic [14:0] sprite_color;
   logic        sprite_opaque;
   logic [1:0]  sprite_priority;
   logic        sprite_semitransparent;
   logic [5:0]  window_mask;

   modport source (
      output valid, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel, sprite_color,
             sprite_opaque, sprite_priority, sprite_semitransparent, window_mask,
      input  ready
   );
   modport sink (
      input  valid, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel, sprite_color,
             sprite_opaque, sprite_priority, sprite_semitransparent, window_mask,
      output ready
   );
endinterface

// ===== rtl/core/lpc_rsp_if.sv =====
interface lpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_color;

   modport source (output valid, pixel_color, input ready);
   modport sink   (input valid, pixel_color, output ready);
endinterface

// ===== rtl/core/lpc_layer_select.sv =====
module lpc_layer_select (
   input  lpc_pkg::req_type px,
   input  lpc_pkg::cfg_type cfg,
   output lpc_pkg::sel_type sel
);

   logic [7:0]  top_code;
   logic [7:0]  back_code;
   logic [15:0] top_pix;
   logic [15:0] back_pix;
   logic [7:0]  cp;
   logic [4:0]  win_vis;
   logic        fx_allowed;
   logic        second_ok;
   logic [5:0]  first_tgt;
   logic [5:0]  second_tgt;
   logic [1:0]  effect;

   assign win_vis    = cfg.windows_enabled ? px.window_mask[4:0] : 5'h1F;
   assign fx_allowed = !cfg.windows_enabled || px.window_mask[5];
   assign first_tgt  = cfg.blend_control[5:0];
   assign second_tgt = cfg.blend_control[13:8];
   assign effect     = cfg.blend_control[7:6];

   // walk the layers in order: four backgrounds, then the sprite
   always_comb begin
      top_code  = lpc_pkg::TOP_INIT;
      back_code = lpc_pkg::TOP_INIT;
      top_pix   = cfg.backdrop_color;
      back_pix  = cfg.backdrop_color;
      cp        = '0;
      for (int l = 0; l < 4; l++) begin
         if (cfg.layer_enable[l] && px.bg_pixel[l][lpc_pkg::OPAQUE_BIT]) begin
            cp = {2'b00, cfg.bg_priorities[2*l +: 2], 4'(l)};
            if (cp < back_code && cp > top_code) begin
               back_pix  = px.bg_pixel[l];
               back_code = cp;
            end else if (cp < top_code && win_vis[l]) begin
               back_pix  = top_pix;
               top_pix   = px.bg_pixel[l];
               back_code = top_code;
               top_code  = cp;
            end
         end
      end
      if (cfg.layer_enable[4] && px.sprite_opaque) begin
         // sprite wins a tie: compare priority fields only
         cp = {2'b00, px.sprite_priority, 4'h0};
         if (cp <= {back_code[7:4], 4'h0} && cp > {top_code[7:4], 4'h0}) begin
            back_pix  = {1'b1, px.sprite_color};
            back_code = cp | 8'h04;
         end else if (cp <= {top_code[7:4], 4'h0} && win_vis[4]) begin
            back_pix  = top_pix;
            top_pix   = {1'b1, px.sprite_color};
            back_code = top_code;
            top_code  = cp | 8'h04;
         end
      end
   end

   assign second_ok = second_tgt[back_code[2:0]];

   always_comb begin
      sel.top_id     = top_code[2:0];
      sel.back_id    = back_code[2:0];
      sel.top_pix    = top_pix;
      sel.back_color = back_pix[14:0];
      sel.fx_op      = lpc_pkg::FX_NONE;
      if (top_code[2:0] == lpc_pkg::LAYER_SPRITE && px.sprite_semitransparent) begin
         // forced blend, regardless of effect field and first target; the second target must still match
         if (second_ok) begin
            sel.fx_op = lpc_pkg::FX_ALPHA;
         end
      end else if (fx_allowed && first_tgt[top_code[2:0]]) begin
         case (effect)
            lpc_pkg::FX_ALPHA: begin
               if (second_ok) begin
                  sel.fx_op = lpc_pkg::FX_ALPHA;
               end
            end
            lpc_pkg::FX_BRIGHTEN: sel.fx_op = lpc_pkg::FX_BRIGHTEN;
            lpc_pkg::FX_DARKEN:   sel.fx_op = lpc_pkg::FX_DARKEN;
            default:              sel.fx_op = lpc_pkg::FX_NONE;
         endcase
      end
   end

endmodule

// ===== rtl/core/layer_priority_compositor_blend.sv =====
// Per-pixel layer compositor with color effects.
// req_ch carries one pixel position per transfer: four background pixels,
// the sprite pixel with its priority and flags, and the window mask.
// rsp_ch returns one composited pixel_color per request, in order.
// The csr_ port writes the eight configuration registers; write them only
// while the pipeline is empty. Coefficient writes above 16 store 16.
// Pipeline: input register, layer select, effect multiply, effect combine.
// A request passes through these four registers in order before its result
// can transfer. Throughput is one pixel per cycle while rsp_ch is not
// stalled; each of the four register stages takes a new pixel every cycle.
// The three channel products of each coefficient run in parallel in the
// multiply stage, so no unit is shared between pixels.
// Reset (synchronous, active high) clears the configuration and the stage
// valid registers, which empties the pipeline. When rsp_ch is stalled the
// stages fill up and hold their contents; req_ch.ready drops only once all
// four stages are occupied, and nothing is lost or repeated.
module layer_priority_compositor_blend (
   input  logic        clock,
   input  logic        reset,
   lpc_req_if.sink     req_ch,
   lpc_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   lpc_pkg::cfg_type cfg_ff;
   lpc_pkg::cfg_type cfg_in;
   logic [4:0]       csr_coef;

   // saturate coefficient writes at 16
   assign csr_coef = (csr_wdata[4:0] > lpc_pkg::COEF_MAX) ? lpc_pkg::COEF_MAX
                                                          : csr_wdata[4:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lpc_pkg::CSR_LAYER_ENABLE:    cfg_in.layer_enable    = csr_wdata[4:0];
            lpc_pkg::CSR_BG_PRIORITIES:   cfg_in.bg_priorities   = csr_wdata[7:0];
            lpc_pkg::CSR_BLEND_CONTROL:   cfg_in.blend_control   = csr_wdata[13:0];
            lpc_pkg::CSR_ALPHA_FIRST:     cfg_in.alpha_first     = csr_coef;
            lpc_pkg::CSR_ALPHA_SECOND:    cfg_in.alpha_second    = csr_coef;
            lpc_pkg::CSR_BRIGHTNESS_STEP: cfg_in.brightness_step = csr_coef;
            lpc_pkg::CSR_WINDOWS_ENABLED: cfg_in.windows_enabled = csr_wdata[0];
            lpc_pkg::CSR_BACKDROP_COLOR:  cfg_in.backdrop_color  = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control: a stage loads when it is empty or its content moves on
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4 = !s4_vld_ff || rsp_ch.ready;
   assign adv3 = !s3_vld_ff || adv4;
   assign adv2 = !s2_vld_ff || adv3;
   assign adv1 = !s1_vld_ff || adv2;

   assign req_ch.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (adv1) s1_vld_ff <= req_ch.valid;
         if (adv2) s2_vld_ff <= s1_vld_ff;
         if (adv3) s3_vld_ff <= s2_vld_ff;
         if (adv4) s4_vld_ff <= s3_vld_ff;
      end
   end

   // stage 1: capture the request
   lpc_pkg::req_type s1_req_ff;
   lpc_pkg::req_type s1_req_in;

   always_comb begin
      s1_req_in.bg_pixel[0]            = req_ch.bg0_pixel;
      s1_req_in.bg_pixel[1]            = req_ch.bg1_pixel;
      s1_req_in.bg_pixel[2]            = req_ch.bg2_pixel;
      s1_req_in.bg_pixel[3]            = req_ch.bg3_pixel;
      s1_req_in.sprite_color           = req_ch.sprite_color;
      s1_req_in.sprite_opaque          = req_ch.sprite_opaque;
      s1_req_in.sprite_priority        = req_ch.sprite_priority;
      s1_req_in.sprite_semitransparent = req_ch.sprite_semitransparent;
      s1_req_in.window_mask            = req_ch.window_mask;
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_req_ff <= s1_req_in;
   end

   // stage 2: resolve top and second layer, pick the effect
   lpc_pkg::sel_type s2_sel_ff;
   lpc_pkg::sel_type s2_sel_in;

   lpc_layer_select u_layer_select (
      .px  (s1_req_ff),
      .cfg (cfg_ff),
      .sel (s2_sel_in)
   );

   always_ff @(posedge clock) begin
      if (adv2) s2_sel_ff <= s2_sel_in;
   end

   // stage 3: per channel products
   // alpha: p0 = top * first, p1 = back * second
   // brighten: p0 = (31 - top) * step; darken: p0 = top * (16 - step)
   logic [2:0][9:0] s3_p0_ff, s3_p0_in;
   logic [2:0][9:0] s3_p1_ff, s3_p1_in;
   logic [15:0]     s3_top_ff;
   logic [1:0]      s3_op_ff;
   logic [4:0]      mul_b;

   always_comb begin
      case (s2_sel_ff.fx_op)
         lpc_pkg::FX_ALPHA:    mul_b = cfg_ff.alpha_first;
         lpc_pkg::FX_BRIGHTEN: mul_b = cfg_ff.brightness_step;
         default:              mul_b = lpc_pkg::COEF_MAX - cfg_ff.brightness_step;
      endcase
   end

   always_comb begin
      logic [4:0] t;
      logic [4:0] b;
      logic [4:0] mul_a;
      for (int k = 0; k < 3; k++) begin
         t     = s2_sel_ff.top_pix[5*k +: 5];
         b     = s2_sel_ff.back_color[5*k +: 5];
         mul_a = (s2_sel_ff.fx_op == lpc_pkg::FX_BRIGHTEN) ? (lpc_pkg::CHAN_MAX - t) : t;
         s3_p0_in[k] = 10'(mul_a) * 10'(mul_b);
         s3_p1_in[k] = 10'(b) * 10'(cfg_ff.alpha_second);
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_p0_ff  <= s3_p0_in;
         s3_p1_ff  <= s3_p1_in;
         s3_top_ff <= s2_sel_ff.top_pix;
         s3_op_ff  <= s2_sel_ff.fx_op;
      end
   end

   // stage 4: combine, saturate, and pick the final word
   logic [15:0] s4_pix_ff, s4_pix_in;

   always_comb begin
      logic [10:0] sum;
      logic [6:0]  q;
      logic [5:0]  lift;
      logic [4:0]  t;
      logic [14:0] fx;
      fx = '0;
      for (int k = 0; k < 3; k++) begin
         t    = s3_top_ff[5*k +: 5];
         sum  = {1'b0, s3_p0_ff[k]} + {1'b0, s3_p1_ff[k]};
         q    = sum[10:4];
         lift = {1'b0, t} + {1'b0, s3_p0_ff[k][8:4]};
         case (s3_op_ff)
            lpc_pkg::FX_ALPHA: begin
               fx[5*k +: 5] = (q > 7'(lpc_pkg::CHAN_MAX)) ? lpc_pkg::CHAN_MAX : q[4:0];
            end
            lpc_pkg::FX_BRIGHTEN: fx[5*k +: 5] = lift[4:0];
            lpc_pkg::FX_DARKEN:   fx[5*k +: 5] = s3_p0_ff[k][8:4];
            default:              fx[5*k +: 5] = t;
         endcase
      end
      // an applied effect clears bit 15; otherwise pass the chosen word
      s4_pix_in = (s3_op_ff == lpc_pkg::FX_NONE) ? s3_top_ff : {1'b0, fx};
   end

   always_ff @(posedge clock) begin
      if (adv4) s4_pix_ff <= s4_pix_in;
   end

   assign rsp_ch.valid       = s4_vld_ff;
   assign rsp_ch.pixel_color = s4_pix_ff;

   // back-pressure reaches the request side only with every stage occupied
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_vld_ff && s2_vld_ff && s3_vld_ff && s4_vld_ff))
      else $error("request side blocked with an empty stage");

   // a held select stage keeps its contents
   a_sel_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && !adv3) |=> (s2_vld_ff && $stable(s2_sel_ff)))
      else $error("select stage changed while stalled");

   // the top layer, unless it is the backdrop, is an enabled layer
   a_top_enabled: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && s2_sel_ff.top_id != lpc_pkg::LAYER_BACKDROP)
      |-> cfg_ff.layer_enable[s2_sel_ff.top_id])
      else $error("disabled layer selected as top");

   // an effect result never carries bit 15
   a_fx_bit15: assert property (@(posedge clock) disable iff (reset)
      (adv4 && s3_vld_ff && s3_op_ff != lpc_pkg::FX_NONE) |=> !s4_pix_ff[15])
      else $error("effect result with bit 15 set");

endmodule
